### hw/rtl/grid_cell_height_averager_unit_macros.svh
// Assertion helpers shared by the RTL of the grid cell height averager.
// Both expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef GRID_CELL_HEIGHT_AVERAGER_UNIT_MACROS_SVH
`define GRID_CELL_HEIGHT_AVERAGER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GCHAV_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GCHAV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/gchav_pkg.sv
package gchav_pkg;

	localparam int MAX_COLS_DEF   = 64;
	localparam int MAX_ROWS_DEF   = 64;
	localparam int COUNT_BITS_DEF = 16;

	// Shared divider geometry: a 48 bit magnitude over a 31 bit divisor,
	// at most 32 quotient bits.
	localparam int NUM_W = 48;
	localparam int DEN_W = 31;
	localparam int QUO_W = 32;
	localparam int SUM_W = 48;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 3'd4;

	localparam logic OP_ACCUM = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef struct packed {
		logic               op;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic [11:0]        read_cell;
	} in_t;

	typedef struct packed {
		logic [11:0]        cell_used;
		logic               occupied;
		logic signed [31:0] cell_x;
		logic signed [31:0] cell_y;
		logic signed [31:0] mean_height;
		logic [15:0]        sample_count;
		logic               dropped;
	} out_t;

	typedef struct packed {
		logic             start;
		logic             long_mode;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic             ovf;
		logic [QUO_W-1:0] quo;
		logic [DEN_W-1:0] rem;
	} div_res_t;

endpackage

### hw/rtl/gchav_div.sv
module gchav_div #(
	parameter int SHORT_STEPS = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gchav_pkg::div_req_t req,
	output gchav_pkg::div_res_t res
);
	import gchav_pkg::*;

	localparam int SH_W  = DEN_W + QUO_W;
	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [NUM_W-1:0] rem_q;
	logic [SH_W-1:0]  dsh_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] left_q;
	logic             busy_q;
	logic             done_q;
	logic             ovf_q;
	logic [SH_W-1:0]  num_ext;
	logic [SH_W-1:0]  rem_ext;
	logic [SH_W-1:0]  lim;
	logic [SH_W-1:0]  dsh_init;
	logic             take;

	assign num_ext = SH_W'(req.num);
	assign rem_ext = SH_W'(rem_q);

	// A quotient that does not fit in the step count is flagged up front;
	// the caller treats it as out of range.
	assign lim = req.long_mode ? (SH_W'(req.den) << QUO_W) : (SH_W'(req.den) << SHORT_STEPS);
	assign dsh_init = req.long_mode ? (SH_W'(req.den) << (QUO_W - 1)) :
		(SH_W'(req.den) << (SHORT_STEPS - 1));
	assign take = rem_ext >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			left_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				left_q <= req.long_mode ? CNT_W'(QUO_W) : CNT_W'(SHORT_STEPS);
			end else if (busy_q) begin
				left_q <= left_q - CNT_W'(1);
				if (left_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// One restoring step per cycle, divisor walking down one bit at a time.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			dsh_q <= dsh_init;
			quo_q <= '0;
			ovf_q <= num_ext >= lim;
		end else if (busy_q) begin
			if (take) begin
				rem_q <= rem_q - dsh_q[NUM_W-1:0];
			end
			quo_q <= {quo_q[QUO_W-2:0], take};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign res = '{busy: busy_q, done: done_q, ovf: ovf_q, quo: quo_q, rem: rem_q[DEN_W-1:0]};

endmodule

### hw/rtl/grid_cell_height_averager_unit.sv
// Grid cell height averager. Each request either snaps a point to the nearest grid column and
// row and adds its height to that cell's sum and sample count, or reads one cell (grid
// coordinates, occupancy, count and mean height) and clears it; every request gives exactly
// one result. The block works on one request at a time: in_ready is high only when it is
// idle, while a finished result waits in the output register. All long arithmetic goes
// through one shared restoring divider that produces one quotient bit per cycle: a point
// uses it for the x and y snaps, and a read for the cell split and the 32-bit mean
// division. After reset the cell store is swept clean, one cell per cycle over all
// MAX_COLS * MAX_ROWS cells (4096 at the defaults), with in_ready low; configuration
// writes are taken throughout and must only be issued while the block is idle.
`include "grid_cell_height_averager_unit_macros.svh"

module grid_cell_height_averager_unit #(
	parameter int MAX_COLS   = gchav_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS   = gchav_pkg::MAX_ROWS_DEF,
	parameter int COUNT_BITS = gchav_pkg::COUNT_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  gchav_pkg::in_t                       in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output gchav_pkg::out_t                      out_data,
	input  logic                                 cfg_we,
	input  logic [gchav_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gchav_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import gchav_pkg::*;

	localparam int CELLS  = MAX_COLS * MAX_ROWS;
	localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int IDX_W  = (CELL_W > 12) ? CELL_W : 12;
	localparam int MAXD   = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
	localparam int DW     = $clog2(MAXD + 1);
	localparam int MEM_W  = SUM_W + COUNT_BITS;
	localparam int PW     = DW + DEN_W;
	localparam int AW     = PW + 2;
	localparam logic [COUNT_BITS-1:0] CNT_FULL = '1;

	typedef enum logic [15:0] {
		S_CLEAR  = 16'h0001,
		S_IDLE   = 16'h0002,
		S_XSNAP  = 16'h0004,
		S_XWAIT  = 16'h0008,
		S_YSNAP  = 16'h0010,
		S_YWAIT  = 16'h0020,
		S_INDEX  = 16'h0040,
		S_RSPLIT = 16'h0080,
		S_RWAIT  = 16'h0100,
		S_MRD    = 16'h0200,
		S_MEM    = 16'h0400,
		S_MWAIT  = 16'h0800,
		S_CX     = 16'h1000,
		S_CXS    = 16'h2000,
		S_CYS    = 16'h4000,
		S_DONE   = 16'h8000
	} state_t;

	state_t              state_q;
	logic [CELL_W-1:0]   clr_q;
	logic                out_valid_q;
	out_t                out_q;
	out_t                res_q;
	in_t                 req_q;

	logic signed [31:0]  x_origin_q;
	logic signed [31:0]  y_origin_q;
	logic [DEN_W-1:0]    cell_size_q;
	logic [6:0]          grid_cols_q;
	logic [6:0]          grid_rows_q;

	logic [DW-1:0]       cols_c;
	logic [DW-1:0]       rows_c;
	logic [DW-1:0]       col_q;
	logic [DW-1:0]       row_q;
	logic [IDX_W-1:0]    idx_q;
	logic [PW-1:0]       prod_q;
	logic                mean_neg_q;

	div_req_t            div_req;
	div_res_t            div_res;

	logic                on_x;
	logic signed [31:0]  snap_p;
	logic signed [31:0]  snap_o;
	logic signed [32:0]  snap_d;
	logic [DW-1:0]       snap_n;
	logic                tie_up;
	logic [DW:0]         snap_j;
	logic [DW-1:0]       snap_idx;

	logic [2*DW-1:0]     area;
	logic                in_range;
	logic [2*DW-1:0]     lin;

	logic [MEM_W-1:0]    store_mem [CELLS];
	logic [MEM_W-1:0]    mem_rd_q;
	logic                mem_we;
	logic [CELL_W-1:0]   mem_waddr;
	logic [MEM_W-1:0]    mem_wdata;
	logic signed [SUM_W-1:0] rd_sum;
	logic [COUNT_BITS-1:0]   rd_cnt;
	logic [NUM_W-1:0]        rd_mag;
	logic                    cnt_full;
	logic [COUNT_BITS-1:0]   cnt_new;
	logic [SUM_W:0]          acc_sum;
	logic [SUM_W-1:0]        acc_sat;

	logic [DW-1:0]       mul_a;
	logic signed [31:0]  add_org;
	logic [AW-1:0]       coord;
	logic [31:0]         coord_sat;
	logic [31:0]         mean_val;
	logic                load_out;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q  <= '0;
			y_origin_q  <= '0;
			cell_size_q <= 31'd65536;
			grid_cols_q <= 7'd64;
			grid_rows_q <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_X_ORIGIN:  x_origin_q  <= cfg_data;
				REG_Y_ORIGIN:  y_origin_q  <= cfg_data;
				REG_CELL_SIZE: cell_size_q <= cfg_data[DEN_W-1:0];
				REG_GRID_COLS: grid_cols_q <= cfg_data[6:0];
				REG_GRID_ROWS: grid_rows_q <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (grid_cols_q == '0) begin
			cols_c = DW'(1);
		end else if (32'(grid_cols_q) > 32'(MAX_COLS)) begin
			cols_c = DW'(MAX_COLS);
		end else begin
			cols_c = DW'(grid_cols_q);
		end
		if (grid_rows_q == '0) begin
			rows_c = DW'(1);
		end else if (32'(grid_rows_q) > 32'(MAX_ROWS)) begin
			rows_c = DW'(MAX_ROWS);
		end else begin
			rows_c = DW'(grid_rows_q);
		end
	end

	// Snapping: with d = p - origin >= 0, q = d / size and remainder r, the nearest
	// grid point is q unless 2r > size, then q + 1, so a tie goes to q. A negative d, a zero
	// size or an index past the grid all land on index 0.
	assign on_x     = (state_q == S_XSNAP) || (state_q == S_XWAIT);
	assign snap_p   = on_x ? req_q.point_x : req_q.point_y;
	assign snap_o   = on_x ? x_origin_q : y_origin_q;
	assign snap_d   = {snap_p[31], snap_p} - {snap_o[31], snap_o};
	assign snap_n   = on_x ? cols_c : rows_c;
	assign tie_up   = {div_res.rem, 1'b0} > {1'b0, cell_size_q};
	assign snap_j   = {1'b0, div_res.quo[DW-1:0]} + {{DW{1'b0}}, tie_up};
	assign snap_idx = (!div_res.ovf && (snap_j < {1'b0, snap_n})) ? snap_j[DW-1:0] : '0;

	assign area     = cols_c * rows_c;
	assign in_range = 32'(req_q.read_cell) < 32'(area);
	assign lin      = row_q * cols_c + (2*DW)'(col_q);

	// Cell store: one write port, one registered read port.
	assign rd_sum   = mem_rd_q[MEM_W-1:COUNT_BITS];
	assign rd_cnt   = mem_rd_q[COUNT_BITS-1:0];
	assign rd_mag   = rd_sum[SUM_W-1] ? (~rd_sum + NUM_W'(1)) : rd_sum;
	assign cnt_full = rd_cnt == CNT_FULL;
	assign cnt_new  = cnt_full ? rd_cnt : (rd_cnt + COUNT_BITS'(1));
	assign acc_sum  = {rd_sum[SUM_W-1], rd_sum} + {{(SUM_W - 31){req_q.point_z[31]}}, req_q.point_z};

	always_comb begin
		if (acc_sum[SUM_W] != acc_sum[SUM_W-1]) begin
			acc_sat = acc_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			acc_sat = acc_sum[SUM_W-1:0];
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[CELL_W-1:0];
		mem_wdata = '0;
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
		end else if (state_q == S_MEM) begin
			if (req_q.op == OP_READ) begin
				mem_we = 1'b1;
			end else begin
				mem_we    = !cnt_full;
				mem_wdata = {acc_sat, cnt_new};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[mem_waddr] <= mem_wdata;
		end
		mem_rd_q <= store_mem[idx_q[CELL_W-1:0]];
	end

	// Requests to the shared divider.
	always_comb begin
		div_req = '0;
		case (state_q)
			S_XSNAP, S_YSNAP: begin
				div_req.start = !snap_d[32];
				div_req.num   = NUM_W'(snap_d[31:0]);
				div_req.den   = cell_size_q;
			end
			S_RSPLIT: begin
				div_req.start = in_range;
				div_req.num   = NUM_W'(req_q.read_cell);
				div_req.den   = DEN_W'(cols_c);
			end
			S_MEM: begin
				div_req.start     = (req_q.op == OP_READ) && (rd_cnt != '0);
				div_req.long_mode = 1'b1;
				div_req.num       = rd_mag;
				div_req.den       = DEN_W'(rd_cnt);
			end
			default: begin
			end
		endcase
	end

	gchav_div #(
		.SHORT_STEPS(DW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	// Grid coordinates: one multiplier and one saturating adder, used for x then y.
	assign mul_a   = (state_q == S_CX) ? col_q : row_q;
	assign add_org = (state_q == S_CXS) ? x_origin_q : y_origin_q;
	assign coord   = {{(AW - 32){add_org[31]}}, add_org} + {2'b00, prod_q};

	always_comb begin
		if ((&coord[AW-1:31]) || !(|coord[AW-1:31])) begin
			coord_sat = coord[31:0];
		end else begin
			coord_sat = coord[AW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
	end

	// Mean magnitude comes back unsigned; apply the sign and saturate.
	always_comb begin
		if (mean_neg_q) begin
			if (div_res.ovf || (div_res.quo > 32'h8000_0000)) begin
				mean_val = 32'h8000_0000;
			end else begin
				mean_val = ~div_res.quo + 32'd1;
			end
		end else begin
			if (div_res.ovf || div_res.quo[31]) begin
				mean_val = 32'h7FFF_FFFF;
			end else begin
				mean_val = div_res.quo;
			end
		end
	end

	assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + CELL_W'(1);
					if (clr_q == CELL_W'(CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= (in_data.op == OP_READ) ? S_RSPLIT : S_XSNAP;
					end
				end
				S_XSNAP: state_q <= snap_d[32] ? S_YSNAP : S_XWAIT;
				S_XWAIT: begin
					if (div_res.done) begin
						state_q <= S_YSNAP;
					end
				end
				S_YSNAP: state_q <= snap_d[32] ? S_INDEX : S_YWAIT;
				S_YWAIT: begin
					if (div_res.done) begin
						state_q <= S_INDEX;
					end
				end
				S_INDEX:  state_q <= S_MRD;
				S_RSPLIT: state_q <= in_range ? S_RWAIT : S_DONE;
				S_RWAIT: begin
					if (div_res.done) begin
						state_q <= S_MRD;
					end
				end
				S_MRD: state_q <= S_MEM;
				S_MEM: begin
					state_q <= ((req_q.op == OP_READ) && (rd_cnt != '0)) ? S_MWAIT : S_CX;
				end
				S_MWAIT: begin
					if (div_res.done) begin
						state_q <= S_CX;
					end
				end
				S_CX:  state_q <= S_CXS;
				S_CXS: state_q <= S_CYS;
				S_CYS: state_q <= S_DONE;
				S_DONE: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				req_q <= in_data;
			end
			S_XSNAP: begin
				col_q <= '0;
			end
			S_XWAIT: begin
				col_q <= snap_idx;
			end
			S_YSNAP: begin
				row_q <= '0;
			end
			S_YWAIT: begin
				row_q <= snap_idx;
			end
			S_INDEX: begin
				idx_q <= IDX_W'(lin);
			end
			S_RSPLIT: begin
				idx_q <= IDX_W'(req_q.read_cell);
				res_q <= '{cell_used: req_q.read_cell, default: '0};
			end
			S_RWAIT: begin
				row_q <= div_res.quo[DW-1:0];
				col_q <= div_res.rem[DW-1:0];
			end
			S_MEM: begin
				mean_neg_q            <= rd_sum[SUM_W-1];
				res_q.cell_used       <= idx_q[11:0];
				res_q.mean_height     <= '0;
				if (req_q.op == OP_READ) begin
					res_q.occupied     <= rd_cnt != '0;
					res_q.sample_count <= (32'(rd_cnt) > 32'd65535) ? 16'hFFFF : 16'(rd_cnt);
					res_q.dropped      <= 1'b0;
				end else begin
					res_q.occupied     <= 1'b1;
					res_q.sample_count <= (32'(cnt_new) > 32'd65535) ? 16'hFFFF : 16'(cnt_new);
					res_q.dropped      <= cnt_full;
				end
			end
			S_MWAIT: begin
				res_q.mean_height <= mean_val;
			end
			S_CX: begin
				prod_q <= {{DEN_W{1'b0}}, mul_a} * {{DW{1'b0}}, cell_size_q};
			end
			S_CXS: begin
				res_q.cell_x <= coord_sat;
				prod_q       <= {{DEN_W{1'b0}}, mul_a} * {{DW{1'b0}}, cell_size_q};
			end
			S_CYS: begin
				res_q.cell_y <= coord_sat;
			end
			S_DONE: begin
				if (load_out) begin
					out_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`GCHAV_ASSERT_SAME(a_div_no_restart, div_req.start, !div_res.busy, "divider restarted while busy")
	`GCHAV_ASSERT_SAME(a_mem_write_state, mem_we, (state_q == S_CLEAR) || (state_q == S_MEM), "cell store written outside clear or update")
	`GCHAV_ASSERT_SAME(a_drop_full_cell, out_valid && out_data.dropped, out_data.occupied && (out_data.sample_count != 16'd0), "dropped point reported on an empty cell")
	`GCHAV_ASSERT_NEXT(a_result_loaded, load_out, out_valid_q && (state_q == S_IDLE), "finished result not presented")

endmodule
